// ===== hw/rtl/rtsm_pkg.sv =====
// Package: shared constants, codes and types of the receive timestamp matcher.
`timescale 1ns / 1ps
`default_nettype none

package rtsm_pkg;

    // Field widths.
    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;
    localparam int WIN_W   = 32;

    // Default number of event slots in the cell row.
    localparam int EVENT_SLOTS_DEF = 64;

    // Reset values.
    localparam logic [WIN_W-1:0]  WINDOW_RESET  = 32'd400000;
    localparam logic [TIME_W-1:0] LATENCY_RESET = 64'd12000;

    // Input operation codes.
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration port: two 32-bit registers at byte offsets 0 and 4.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_RX_ENABLE    = 1'b0;
    localparam logic REG_MATCH_WINDOW = 1'b1;

    // Commands from the controller to the cell row.
    typedef struct packed {
        logic shift;   // rotate every cell by one place toward the head
        logic load;    // write load data into the addressed cell
        logic clear;   // empty the addressed cell
    } row_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtsm_if.sv =====
// Interfaces: input item channel and result channel of the timestamp matcher.
`timescale 1ns / 1ps
`default_nettype none

interface rtsm_in_if;
    import rtsm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [TIME_W-1:0]    tick_time;
    logic [COUNT_W-1:0]   frame_count;

    modport source (output valid, output op, output tick_time, output frame_count,
                    input ready);
    modport sink   (input valid, input op, input tick_time, input frame_count,
                    output ready);
endinterface

interface rtsm_out_if;
    import rtsm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         stamp;
    logic                      matched;
    logic signed [TIME_W-1:0]  latency_ticks;
    logic [COUNT_W-1:0]        match_total;
    logic [COUNT_W-1:0]        miss_total;

    modport source (output valid, output stamp, output matched, output latency_ticks,
                    output match_total, output miss_total, input ready);
    modport sink   (input valid, input stamp, input matched, input latency_ticks,
                    input match_total, input miss_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rx_timestamp_nearest_match.sv =====
// Top level: receive timestamp matcher with a rotating cell row and one distance unit.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------------
//  in_ch    | in  | valid/ready        | op, tick_time, frame_count
//  out_ch   | out | valid/ready        | stamp, matched, latency_ticks, totals
//  apb      | in  | psel/penable/pready| paddr, pwdata, prdata (rx_enable, match_window)
//
// An enabled query passes through the target, scan, decide, train and update states from
// acceptance to the result register: the cell row rotates once past the single distance
// unit at its head, then the decide, train and update states decide, train and commit.
// Disabled queries are accepted and dropped. Reset empties all slots at once.
// A query whose result finds the output register still full waits before committing.
`timescale 1ns / 1ps
`default_nettype none

module rx_timestamp_nearest_match #(
    parameter int EVENT_SLOTS = rtsm_pkg::EVENT_SLOTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rtsm_in_if.sink                                in_ch,
    rtsm_out_if.source                             out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rtsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rtsm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rtsm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import rtsm_pkg::*;

    localparam int SLOT_W = $clog2(EVENT_SLOTS);
    localparam int CNT_W  = $clog2(EVENT_SLOTS + 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TARGET = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_TRAIN  = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Configuration registers.
    logic              rx_enable_reg;
    logic [WIN_W-1:0]  match_window_reg;

    // Event bookkeeping and statistics.
    logic [SLOT_W-1:0]   write_slot_reg;
    logic [COUNT_W-1:0]  prev_count_reg;
    logic                primed_reg;
    logic [TIME_W-1:0]   latency_reg;
    logic [COUNT_W-1:0]  hit_count_reg;
    logic [COUNT_W-1:0]  miss_count_reg;

    // Query working registers.
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   target_reg;
    logic [CNT_W-1:0]    scan_cnt_reg;

    // Distance pipeline at the head of the row.
    logic                s1_valid_reg;
    logic [TIME_W-1:0]   s1_diff_reg;
    logic [TIME_W-1:0]   s1_event_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic                s2_valid_reg;
    logic [TIME_W-1:0]   s2_dist_reg;
    logic [TIME_W-1:0]   s2_event_reg;
    logic [SLOT_W-1:0]   s2_slot_reg;

    // Running best candidate.
    logic                best_found_reg;
    logic [TIME_W-1:0]   best_dist_reg;
    logic [TIME_W-1:0]   best_event_reg;
    logic [SLOT_W-1:0]   best_slot_reg;

    // Decision and training.
    logic                hit_reg;
    logic [TIME_W-1:0]   delay_reg;
    logic                trains_reg;
    logic [TIME_W-1:0]   step_reg;

    // Output register.
    logic                out_valid_reg;
    logic [TIME_W-1:0]   out_stamp_reg;
    logic                out_matched_reg;
    logic [TIME_W-1:0]   out_latency_reg;
    logic [COUNT_W-1:0]  out_hits_reg;
    logic [COUNT_W-1:0]  out_misses_reg;

    row_cmd_t            row_cmd;
    logic [SLOT_W-1:0]   row_slot;
    logic [TIME_W-1:0]   row_head;

    logic                in_beat;
    logic                out_free;
    logic                scan_rotate;
    logic                store_event;
    logic                cfg_write;
    logic                s2_better;
    logic [TIME_W-1:0]   latency_new;
    logic signed [TIME_W+1:0] delay_wide;
    logic signed [TIME_W+1:0] lat_times4;
    logic signed [TIME_W:0]   train_diff;

    // Cell row holding the event times.
    rtsm_cell_row #(
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (row_cmd),
        .slot      (row_slot),
        .load_data (in_ch.tick_time),
        .head      (row_head)
    );

    // Handshake and sequencing conditions.
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_beat     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign scan_rotate = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_W'(EVENT_SLOTS));
    assign store_event = in_beat && (in_ch.op == OP_EVENT) && primed_reg
                         && (in_ch.frame_count != prev_count_reg);

    // Row commands: rotate during the scan, load on a stored event, clear on a hit.
    always_comb
    begin
        row_cmd.shift = scan_rotate;
        row_cmd.load  = store_event;
        row_cmd.clear = (state_reg == ST_TRAIN) && hit_reg;
        row_slot      = (state_reg == ST_TRAIN) ? best_slot_reg : write_slot_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (in_ch.op == OP_QUERY) && rx_enable_reg)
                begin
                    state_next = ST_TARGET;
                end
            end
            ST_TARGET:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == CNT_W'(EVENT_SLOTS + 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_TRAIN;
            end
            ST_TRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_enable_reg    <= 1'b0;
            match_window_reg <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_RX_ENABLE:    rx_enable_reg    <= pwdata[0];
                REG_MATCH_WINDOW: match_window_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_RX_ENABLE:    prdata = {{(APB_DATA_W-1){1'b0}}, rx_enable_reg};
            REG_MATCH_WINDOW: prdata = match_window_reg;
            default:          prdata = '0;
        endcase
    end

    // Event records: advance the ring on a new frame count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            prev_count_reg <= '0;
            primed_reg     <= 1'b0;
        end
        else if (in_beat && (in_ch.op == OP_EVENT))
        begin
            if (store_event)
            begin
                write_slot_reg <= (write_slot_reg == SLOT_W'(EVENT_SLOTS - 1))
                                  ? '0 : write_slot_reg + 1'b1;
            end
            prev_count_reg <= in_ch.frame_count;
            primed_reg     <= 1'b1;
        end
    end

    // Query capture, target and scan counter.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            now_reg <= in_ch.tick_time;
        end
        if (state_reg == ST_TARGET)
        begin
            target_reg <= now_reg - latency_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        else
        begin
            scan_cnt_reg <= '0;
        end
    end

    // Distance pipeline: difference, then magnitude, then compare with the best.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= scan_rotate;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diff_reg  <= target_reg - row_head;
        s1_event_reg <= row_head;
        s1_slot_reg  <= scan_cnt_reg[SLOT_W-1:0];
        s2_dist_reg  <= s1_diff_reg[TIME_W-1] ? (TIME_W'(0) - s1_diff_reg) : s1_diff_reg;
        s2_event_reg <= s1_event_reg;
        s2_slot_reg  <= s1_slot_reg;
    end

    // Empty slots never win; on equal distance the earlier (lower) slot stays.
    assign s2_better = s2_valid_reg && (s2_event_reg != '0)
                       && (!best_found_reg || (s2_dist_reg < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
        end
        else if (state_reg == ST_TARGET)
        begin
            best_found_reg <= 1'b0;
        end
        else if (s2_better)
        begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_better)
        begin
            best_dist_reg  <= s2_dist_reg;
            best_event_reg <= s2_event_reg;
            best_slot_reg  <= s2_slot_reg;
        end
    end

    // Window check and delay of the chosen event.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
        begin
            hit_reg   <= best_found_reg
                         && (best_dist_reg <= {{(TIME_W-WIN_W){1'b0}}, match_window_reg});
            delay_reg <= now_reg - best_event_reg;
        end
    end

    // Training: exact signed compare against four times the latency, and the 1/32 step.
    assign delay_wide = $signed({{2{delay_reg[TIME_W-1]}}, delay_reg});
    assign lat_times4 = $signed({latency_reg, 2'b00});
    assign train_diff = $signed({delay_reg[TIME_W-1], delay_reg})
                        - $signed({latency_reg[TIME_W-1], latency_reg});

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TRAIN)
        begin
            trains_reg <= hit_reg && (delay_wide < lat_times4);
            step_reg   <= TIME_W'(train_diff >>> 5);
        end
    end

    assign latency_new = trains_reg ? (latency_reg + step_reg) : latency_reg;

    // Commit: latency, counters and the result register move together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg    <= LATENCY_RESET;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_UPDATE) && out_free)
            begin
                latency_reg   <= latency_new;
                out_valid_reg <= 1'b1;
                if (hit_reg)
                begin
                    hit_count_reg <= hit_count_reg + 1'b1;
                end
                else
                begin
                    miss_count_reg <= miss_count_reg + 1'b1;
                end
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_UPDATE) && out_free)
        begin
            out_stamp_reg   <= hit_reg ? best_event_reg : target_reg;
            out_matched_reg <= hit_reg;
            out_latency_reg <= latency_new;
            out_hits_reg    <= hit_reg ? hit_count_reg + 1'b1 : hit_count_reg;
            out_misses_reg  <= hit_reg ? miss_count_reg : miss_count_reg + 1'b1;
        end
    end

    // Result beat.
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.stamp         = out_stamp_reg;
    assign out_ch.matched       = out_matched_reg;
    assign out_ch.latency_ticks = $signed(out_latency_reg);
    assign out_ch.match_total   = out_hits_reg;
    assign out_ch.miss_total    = out_misses_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rtsm_cell.sv =====
// One event slot of the cell row: holds a capture time, shifts, loads or clears.
`timescale 1ns / 1ps
`default_nettype none

module rtsm_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rtsm_pkg::row_cmd_t          cmd,
    input  wire logic                        sel,
    input  wire logic [rtsm_pkg::TIME_W-1:0] load_data,
    input  wire logic [rtsm_pkg::TIME_W-1:0] shift_in,
    output logic      [rtsm_pkg::TIME_W-1:0] value
);
    import rtsm_pkg::*;

    logic [TIME_W-1:0] val_reg;

    // Rotation has priority; loads and clears only happen while the row is still.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            priority if (cmd.shift)
            begin
                val_reg <= shift_in;
            end
            else if (sel && cmd.load)
            begin
                val_reg <= load_data;
            end
            else if (sel && cmd.clear)
            begin
                val_reg <= '0;
            end
            else
            begin
                val_reg <= val_reg;
            end
        end
    end

    assign value = val_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rtsm_cell_row.sv =====
// Ring of event cells; the head cell is visible to the distance unit.
`timescale 1ns / 1ps
`default_nettype none

module rtsm_cell_row #(
    parameter int EVENT_SLOTS = rtsm_pkg::EVENT_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rtsm_pkg::row_cmd_t             cmd,
    input  wire logic [$clog2(EVENT_SLOTS)-1:0] slot,
    input  wire logic [rtsm_pkg::TIME_W-1:0]    load_data,
    output logic      [rtsm_pkg::TIME_W-1:0]    head
);
    import rtsm_pkg::*;

    localparam int SLOT_W = $clog2(EVENT_SLOTS);

    logic [TIME_W-1:0] cell_value [EVENT_SLOTS];

    // Each cell takes its right neighbor's value on a shift; the head wraps to the last cell.
    for (genvar i = 0; i < EVENT_SLOTS; i++)
    begin : g_cell
        rtsm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel       (slot == SLOT_W'(i)),
            .load_data (load_data),
            .shift_in  (cell_value[(i + 1) % EVENT_SLOTS]),
            .value     (cell_value[i])
        );
    end

    assign head = cell_value[0];

endmodule

`default_nettype wire
